/* rtl/core/mtcd_pkg.sv */
// shared types and constants of the music track command decoder
package mtcd_pkg;

	localparam int TABLE_ENTRIES    = 32;
	localparam int TABLE_IDX_W      = $clog2(TABLE_ENTRIES);
	localparam int TABLE_VAL_W      = 16;
	localparam int TICK_W           = 28;
	localparam int VARLEN_MAX_BYTES = 4;
	localparam int VARLEN_CNT_W     = 3;

	localparam logic [1:0] OP_TABLE_WR    = 2'd0;
	localparam logic [1:0] OP_TRACK_START = 2'd1;
	localparam logic [1:0] OP_STREAM      = 2'd2;

	localparam logic [3:0] EV_NOTE       = 4'd0;
	localparam logic [3:0] EV_END        = 4'd1;
	localparam logic [3:0] EV_TEMPO      = 4'd2;
	localparam logic [3:0] EV_REVERB     = 4'd3;
	localparam logic [3:0] EV_PROGRAM    = 4'd4;
	localparam logic [3:0] EV_VOLUME     = 4'd5;
	localparam logic [3:0] EV_PAN        = 4'd6;
	localparam logic [3:0] EV_EXPRESSION = 4'd7;
	localparam logic [3:0] EV_LOOP       = 4'd8;
	localparam logic [3:0] EV_UNKNOWN    = 4'd9;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [7:0]             data_byte;
		logic [TABLE_IDX_W-1:0] table_index;
		logic [TABLE_VAL_W-1:0] table_value;
	} mtcd_item_t;

	typedef struct packed {
		logic [3:0]        event_kind;
		logic [7:0]        note_number;
		logic [7:0]        velocity;
		logic [TICK_W-1:0] duration_ticks;
		logic [7:0]        control_value;
		logic [TICK_W-1:0] delta_ticks;
	} mtcd_event_t;

endpackage

/* rtl/core/mtcd_in_if.sv */
// input channel carrying track bytes and length table writes
interface mtcd_in_if;
	import mtcd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             opcode;
	logic [7:0]             data_byte;
	logic [TABLE_IDX_W-1:0] table_index;
	logic [TABLE_VAL_W-1:0] table_value;

	modport source (output valid, opcode, data_byte, table_index, table_value, input ready);
	modport sink (input valid, opcode, data_byte, table_index, table_value, output ready);
endinterface

/* rtl/core/mtcd_out_if.sv */
// output channel carrying decoded track events
interface mtcd_out_if;
	import mtcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [3:0]        event_kind;
	logic [7:0]        note_number;
	logic [7:0]        velocity;
	logic [TICK_W-1:0] duration_ticks;
	logic [7:0]        control_value;
	logic [TICK_W-1:0] delta_ticks;

	modport source (output valid, event_kind, note_number, velocity, duration_ticks,
		control_value, delta_ticks, input ready);
	modport sink (input valid, event_kind, note_number, velocity, duration_ticks,
		control_value, delta_ticks, output ready);
endinterface

/* rtl/core/music_track_command_decoder.sv */
// Music track command decoder: takes one beat per clock cycle on the track channel, either a
// length table write, a track start or one track byte, and gives at most one decoded event
// per beat on the events channel. A beat lands in the input register, is decoded from
// there once the result register is free or being drained, and its event, if any, is
// written into the result register, from which it is presented; the sustained rate is one
// beat per cycle, held back only when the events sink stalls. The two length table reads
// of a beat (by the byte itself and by the current command) are registered when the beat
// is taken; the table has no reset and must be written before the track uses an entry.
module music_track_command_decoder
	import mtcd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	mtcd_in_if.sink   track,
	mtcd_out_if.source events
);

	logic                   valid_s1;
	mtcd_item_t             item_s1;
	logic                   advance;
	logic                   take;
	logic [TABLE_VAL_W-1:0] rd_byte;
	logic [TABLE_VAL_W-1:0] rd_sel;
	logic [7:0]             cmd_next;
	logic                   ev_valid;
	mtcd_event_t            ev;
	logic                   out_valid_q;
	mtcd_event_t            out_q;

	assign advance     = valid_s1 && (!out_valid_q || events.ready);
	assign track.ready = !valid_s1 || advance;
	assign take        = track.valid && track.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.opcode      <= track.opcode;
			item_s1.data_byte   <= track.data_byte;
			item_s1.table_index <= track.table_index;
			item_s1.table_value <= track.table_value;
		end
	end

	mtcd_len_table u_table (
		.clk     (clk),
		.we      (advance && item_s1.opcode == OP_TABLE_WR),
		.waddr   (item_s1.table_index),
		.wdata   (item_s1.table_value),
		.re      (take),
		.raddr_a (track.data_byte[TABLE_IDX_W-1:0]),
		.raddr_b (cmd_next[TABLE_IDX_W-1:0]),
		.rdata_a (rd_byte),
		.rdata_b (rd_sel)
	);

	mtcd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.rd_byte  (rd_byte),
		.rd_sel   (rd_sel),
		.cmd_next (cmd_next),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	// result register, one event beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ev_valid;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_valid) begin
			out_q <= ev;
		end
	end

	assign events.valid          = out_valid_q;
	assign events.event_kind     = out_q.event_kind;
	assign events.note_number    = out_q.note_number;
	assign events.velocity       = out_q.velocity;
	assign events.duration_ticks = out_q.duration_ticks;
	assign events.control_value  = out_q.control_value;
	assign events.delta_ticks    = out_q.delta_ticks;

endmodule

/* rtl/core/mtcd_len_table.sv */
// note length table memory with one write port and two registered read ports
module mtcd_len_table
	import mtcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   we,
	input  logic [TABLE_IDX_W-1:0] waddr,
	input  logic [TABLE_VAL_W-1:0] wdata,
	input  logic                   re,
	input  logic [TABLE_IDX_W-1:0] raddr_a,
	input  logic [TABLE_IDX_W-1:0] raddr_b,
	output logic [TABLE_VAL_W-1:0] rdata_a,
	output logic [TABLE_VAL_W-1:0] rdata_b
);

	logic [TABLE_VAL_W-1:0] mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first so a read on the same edge sees the new entry
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
			rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

endmodule

/* rtl/core/mtcd_parser.sv */
// track parse state and per-beat decode of one byte into at most one event
module mtcd_parser
	import mtcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  mtcd_item_t             item,
	input  logic [TABLE_VAL_W-1:0] rd_byte,
	input  logic [TABLE_VAL_W-1:0] rd_sel,
	output logic [7:0]             cmd_next,
	output logic                   ev_valid,
	output mtcd_event_t            ev
);

	localparam logic [3:0] PH_CMD         = 4'd0;
	localparam logic [3:0] PH_NOTE        = 4'd1;
	localparam logic [3:0] PH_DVAR        = 4'd2;
	localparam logic [3:0] PH_DIDX        = 4'd3;
	localparam logic [3:0] PH_LVAR        = 4'd4;
	localparam logic [3:0] PH_VEL         = 4'd5;
	localparam logic [3:0] PH_PARAM       = 4'd6;
	localparam logic [3:0] PH_PARAM_FIRST = 4'd7;

	localparam logic [VARLEN_CNT_W-1:0] VARLEN_INIT = VARLEN_CNT_W'(VARLEN_MAX_BYTES);

	logic [3:0]              phase_q, phase_d;
	logic [7:0]              cmd_q, cmd_d;
	logic [7:0]              note_q, note_d;
	logic [7:0]              vel_q, vel_d;
	logic [TICK_W-1:0]       nlen_q, nlen_d;
	logic [TICK_W-1:0]       cdelta_q, cdelta_d;
	logic [TICK_W-1:0]       ndelta_q, ndelta_d;
	logic [TICK_W-1:0]       acc_q, acc_d;
	logic [VARLEN_CNT_W-1:0] left_q, left_d;
	logic [7:0]              pend_q, pend_d;
	logic                    ended_q, ended_d;

	logic [7:0]  b;
	logic [1:0]  mode;
	logic        vl_done;
	logic        go_delta, go_after_delta, go_length, go_after_length, go_finish;

	function automatic logic [3:0] control_kind(input logic [4:0] sel);
		logic [3:0] k;
		unique case (sel)
			5'h01:   k = EV_TEMPO;
			5'h02:   k = EV_REVERB;
			5'h03:   k = EV_PROGRAM;
			5'h04:   k = EV_VOLUME;
			5'h05:   k = EV_PAN;
			5'h06:   k = EV_EXPRESSION;
			5'h09:   k = EV_LOOP;
			default: k = EV_UNKNOWN;
		endcase
		return k;
	endfunction

	assign b = item.data_byte;

	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		note_d   = note_q;
		vel_d    = vel_q;
		nlen_d   = nlen_q;
		cdelta_d = cdelta_q;
		ndelta_d = ndelta_q;
		acc_d    = acc_q;
		left_d   = left_q;
		pend_d   = pend_q;
		ended_d  = ended_q;
		ev_valid = 1'b0;
		ev       = '0;
		vl_done  = 1'b0;
		go_delta        = 1'b0;
		go_after_delta  = 1'b0;
		go_length       = 1'b0;
		go_after_length = 1'b0;
		go_finish       = 1'b0;
		mode = cmd_q[6:5];

		if (step && item.opcode == OP_TRACK_START) begin
			phase_d  = PH_CMD;
			cmd_d    = '0;
			note_d   = 8'd60;
			vel_d    = 8'd127;
			nlen_d   = '0;
			cdelta_d = '0;
			ndelta_d = '0;
			acc_d    = '0;
			left_d   = VARLEN_INIT;
			pend_d   = '0;
			ended_d  = 1'b0;
		end else if (step && item.opcode == OP_STREAM && !ended_q) begin
			// varlen byte, used only by the varlen phases
			if (phase_q == PH_DVAR || phase_q == PH_LVAR) begin
				acc_d = (acc_q << 7) + TICK_W'(b[6:0]);
				if (left_q != '0) begin
					left_d = left_q - 1'b1;
				end
				vl_done = (left_d == '0) || !b[7];
			end

			unique case (phase_q)
				PH_NOTE: begin
					pend_d   = b;
					note_d   = {1'b0, b[6:0]};
					go_delta = 1'b1;
				end
				PH_DVAR: begin
					if (vl_done) begin
						cdelta_d       = acc_d;
						go_after_delta = 1'b1;
					end
				end
				PH_DIDX: begin
					cdelta_d       = TICK_W'(rd_byte);
					go_after_delta = 1'b1;
				end
				PH_LVAR: begin
					if (vl_done) begin
						nlen_d          = acc_d;
						go_after_length = 1'b1;
					end
				end
				PH_VEL: begin
					vel_d     = b;
					go_finish = 1'b1;
				end
				PH_PARAM_FIRST: begin
					pend_d  = b;
					phase_d = PH_PARAM;
				end
				PH_PARAM: begin
					pend_d   = b;
					go_delta = 1'b1;
				end
				default: begin
					cmd_d  = b;
					pend_d = '0;
					if (!b[7]) begin
						phase_d = PH_NOTE;
					end else if (b[6:5] == 2'd1) begin
						// relative note
						if (b[4]) begin
							note_d = note_q + {4'b0, b[3:0]};
						end else begin
							note_d = note_q - {4'b0, b[3:0]};
						end
						cdelta_d = ndelta_q;
						phase_d  = PH_CMD;
						ev_valid = 1'b1;
						ev.event_kind     = EV_NOTE;
						ev.note_number    = note_d;
						ev.velocity       = vel_q;
						ev.duration_ticks = nlen_q;
						ev.delta_ticks    = ndelta_q;
					end else if (b[4:0] == 5'h00) begin
						ended_d  = 1'b1;
						phase_d  = PH_CMD;
						ev_valid = 1'b1;
						ev.event_kind = EV_END;
					end else if (b[4:0] == 5'h0F) begin
						go_delta = 1'b1;
					end else if (b[4:0] == 5'h07) begin
						phase_d = PH_PARAM_FIRST;
					end else begin
						phase_d = PH_PARAM;
					end
				end
			endcase

			mode = cmd_d[6:5];

			if (go_delta) begin
				if (mode == 2'd2) begin
					acc_d   = '0;
					left_d  = VARLEN_INIT;
					phase_d = PH_DVAR;
				end else if (mode == 2'd3) begin
					phase_d = PH_DIDX;
				end else begin
					go_after_delta = 1'b1;
				end
			end

			if (go_after_delta) begin
				if (cmd_d[7]) begin
					phase_d  = PH_CMD;
					ev_valid = 1'b1;
					ev.event_kind    = control_kind(cmd_d[4:0]);
					ev.control_value = pend_d;
					ev.delta_ticks   = cdelta_d;
				end else begin
					go_length = 1'b1;
				end
			end

			if (go_length) begin
				if (rd_sel != '0) begin
					nlen_d          = TICK_W'(rd_sel);
					go_after_length = 1'b1;
				end else begin
					acc_d   = '0;
					left_d  = VARLEN_INIT;
					phase_d = PH_LVAR;
				end
			end

			if (go_after_length) begin
				if (pend_d[7]) begin
					phase_d = PH_VEL;
				end else begin
					go_finish = 1'b1;
				end
			end

			if (go_finish) begin
				if (mode == 2'd1) begin
					cdelta_d = nlen_d;
				end
				ndelta_d = cdelta_d;
				phase_d  = PH_CMD;
				ev_valid = 1'b1;
				ev.event_kind     = EV_NOTE;
				ev.note_number    = note_d;
				ev.velocity       = vel_d;
				ev.duration_ticks = nlen_d;
				ev.delta_ticks    = cdelta_d;
			end
		end
	end

	assign cmd_next = cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CMD;
			cmd_q    <= '0;
			note_q   <= 8'd60;
			vel_q    <= 8'd127;
			nlen_q   <= '0;
			cdelta_q <= '0;
			ndelta_q <= '0;
			acc_q    <= '0;
			left_q   <= VARLEN_INIT;
			pend_q   <= '0;
			ended_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			note_q   <= note_d;
			vel_q    <= vel_d;
			nlen_q   <= nlen_d;
			cdelta_q <= cdelta_d;
			ndelta_q <= ndelta_d;
			acc_q    <= acc_d;
			left_q   <= left_d;
			pend_q   <= pend_d;
			ended_q  <= ended_d;
		end
	end

endmodule

/* tb/sv/mtcd_cmd_pkg.sv */
// command byte fields used to build and decode track streams in the testbench
package mtcd_cmd_pkg;

	// bits 6:5 of a command byte
	localparam logic [1:0] MODE_FIXED     = 2'd0;
	localparam logic [1:0] MODE_LEN_DELTA = 2'd1;	// relative note for control bytes
	localparam logic [1:0] MODE_VAR_DELTA = 2'd2;
	localparam logic [1:0] MODE_IDX_DELTA = 2'd3;

	// bits 4:0 of a control command byte
	localparam logic [4:0] SEL_END        = 5'h00;
	localparam logic [4:0] SEL_TEMPO      = 5'h01;
	localparam logic [4:0] SEL_REVERB     = 5'h02;
	localparam logic [4:0] SEL_PROGRAM    = 5'h03;
	localparam logic [4:0] SEL_VOLUME     = 5'h04;
	localparam logic [4:0] SEL_PAN        = 5'h05;
	localparam logic [4:0] SEL_EXPRESSION = 5'h06;
	localparam logic [4:0] SEL_TWO_PARAM  = 5'h07;
	localparam logic [4:0] SEL_LOOP       = 5'h09;
	localparam logic [4:0] SEL_NO_PARAM   = 5'h0F;

	localparam logic [1:0] OP_NONE = 2'd3;

endpackage

/* tb/sv/mtcd_event_checker.sv */
// track decoder predictor and event comparison for the music track command decoder bench
module mtcd_event_checker
	import mtcd_pkg::*;
	import mtcd_cmd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mtcd_in_if  track,
	mtcd_out_if events,
	output int  failures,
	output int  outstanding
);

	typedef enum logic [3:0] {
		ST_CMD, ST_NOTE, ST_DELTA_VAR, ST_DELTA_IDX, ST_LEN_VAR, ST_VEL, ST_PARAM, ST_PARAM_FIRST
	} parse_state_t;

	parse_state_t             state;
	logic [7:0]               cmd;
	logic [7:0]               note;
	logic [7:0]               vel;
	logic [7:0]               param;
	logic [TICK_W-1:0]        note_len;
	logic [TICK_W-1:0]        cmd_delta;
	logic [TICK_W-1:0]        note_delta;
	logic [TICK_W-1:0]        acc;
	logic [VARLEN_CNT_W-1:0]  bytes_left;
	logic                     track_done;
	logic [TABLE_VAL_W-1:0]   lengths [TABLE_ENTRIES];
	mtcd_event_t              predicted_events [$];
	int                       fail_cnt = 0;

	function automatic void restart_track();
		state      = ST_CMD;
		cmd        = 8'd0;
		note       = 8'd60;
		vel        = 8'd127;
		note_len   = '0;
		cmd_delta  = '0;
		note_delta = '0;
		acc        = '0;
		bytes_left = VARLEN_CNT_W'(VARLEN_MAX_BYTES);
		param      = 8'd0;
		track_done = 1'b0;
	endfunction

	function automatic void queue_event(logic [3:0] kind, logic [7:0] nn, logic [7:0] v,
			logic [TICK_W-1:0] dur, logic [7:0] cv, logic [TICK_W-1:0] dt);
		mtcd_event_t ev_item;
		ev_item = '{kind, nn, v, dur, cv, dt};
		predicted_events = {predicted_events, ev_item};
	endfunction

	function automatic logic varlen_take(logic [7:0] b);
		acc = (acc << 7) + TICK_W'(b[6:0]);
		if (bytes_left != 0)
			bytes_left--;
		return bytes_left == 0 || !b[7];
	endfunction

	function automatic void decode_beat(logic [1:0] op, logic [7:0] b,
			logic [TABLE_IDX_W-1:0] idx, logic [TABLE_VAL_W-1:0] val);
		logic       to_delta;
		logic       to_after_delta;
		logic       to_after_len;
		logic       to_finish;
		logic [3:0] kind;
		to_delta       = 1'b0;
		to_after_delta = 1'b0;
		to_after_len   = 1'b0;
		to_finish      = 1'b0;
		if (op == OP_TABLE_WR) begin
			lengths[idx] = val;
			return;
		end
		if (op == OP_TRACK_START) begin
			restart_track();
			return;
		end
		if (op != OP_STREAM || track_done)
			return;
		unique case (state)
			ST_NOTE: begin
				param    = b;
				note     = {1'b0, b[6:0]};
				to_delta = 1'b1;
			end
			ST_DELTA_VAR: if (varlen_take(b)) begin
				cmd_delta      = acc;
				to_after_delta = 1'b1;
			end
			ST_DELTA_IDX: begin
				cmd_delta      = TICK_W'(lengths[b[4:0]]);
				to_after_delta = 1'b1;
			end
			ST_LEN_VAR: if (varlen_take(b)) begin
				note_len     = acc;
				to_after_len = 1'b1;
			end
			ST_VEL: begin
				vel       = b;
				to_finish = 1'b1;
			end
			ST_PARAM_FIRST: begin
				param = b;
				state = ST_PARAM;
			end
			ST_PARAM: begin
				param    = b;
				to_delta = 1'b1;
			end
			default: begin
				cmd   = b;
				param = 8'd0;
				if (!b[7]) begin
					state = ST_NOTE;
				end else if (b[6:5] == MODE_LEN_DELTA) begin
					if (b[4])
						note = note + {4'b0, b[3:0]};
					else
						note = note - {4'b0, b[3:0]};
					cmd_delta = note_delta;
					state     = ST_CMD;
					queue_event(EV_NOTE, note, vel, note_len, 8'd0, note_delta);
				end else if (b[4:0] == SEL_END) begin
					track_done = 1'b1;
					state      = ST_CMD;
					queue_event(EV_END, 8'd0, 8'd0, '0, 8'd0, '0);
				end else if (b[4:0] == SEL_NO_PARAM) begin
					to_delta = 1'b1;
				end else if (b[4:0] == SEL_TWO_PARAM) begin
					state = ST_PARAM_FIRST;
				end else begin
					state = ST_PARAM;
				end
			end
		endcase
		if (to_delta) begin
			unique case (cmd[6:5])
				MODE_VAR_DELTA: begin
					acc        = '0;
					bytes_left = VARLEN_CNT_W'(VARLEN_MAX_BYTES);
					state      = ST_DELTA_VAR;
				end
				MODE_IDX_DELTA: state = ST_DELTA_IDX;
				default: to_after_delta = 1'b1;
			endcase
		end
		if (to_after_delta) begin
			if (cmd[7]) begin
				unique case (cmd[4:0])
					SEL_TEMPO:      kind = EV_TEMPO;
					SEL_REVERB:     kind = EV_REVERB;
					SEL_PROGRAM:    kind = EV_PROGRAM;
					SEL_VOLUME:     kind = EV_VOLUME;
					SEL_PAN:        kind = EV_PAN;
					SEL_EXPRESSION: kind = EV_EXPRESSION;
					SEL_LOOP:       kind = EV_LOOP;
					default:        kind = EV_UNKNOWN;
				endcase
				state = ST_CMD;
				queue_event(kind, 8'd0, 8'd0, '0, param, cmd_delta);
			end else if (lengths[cmd[4:0]] != '0) begin
				note_len     = TICK_W'(lengths[cmd[4:0]]);
				to_after_len = 1'b1;
			end else begin
				acc        = '0;
				bytes_left = VARLEN_CNT_W'(VARLEN_MAX_BYTES);
				state      = ST_LEN_VAR;
			end
		end
		if (to_after_len) begin
			if (param[7])
				state = ST_VEL;
			else
				to_finish = 1'b1;
		end
		if (to_finish) begin
			if (cmd[6:5] == MODE_LEN_DELTA)
				cmd_delta = note_len;
			note_delta = cmd_delta;
			state      = ST_CMD;
			queue_event(EV_NOTE, note, vel, note_len, 8'd0, cmd_delta);
		end
	endfunction

	function automatic void check_field(string name, logic [TICK_W-1:0] want,
			logic [TICK_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mtcd_event_t want;
		if (!arst_n) begin
			restart_track();
			foreach (lengths[i])
				lengths[i] = '0;
			predicted_events.delete();
			outstanding <= 0;
		end else begin
			if (events.valid && events.ready) begin
				if (predicted_events.size() == 0) begin
					$error("event_kind %0d arrived with no event predicted", events.event_kind);
					fail_cnt++;
				end else begin
					want = predicted_events.pop_front();
					check_field("event_kind", TICK_W'(want.event_kind),
						TICK_W'(events.event_kind));
					check_field("note_number", TICK_W'(want.note_number),
						TICK_W'(events.note_number));
					check_field("velocity", TICK_W'(want.velocity), TICK_W'(events.velocity));
					check_field("duration_ticks", want.duration_ticks, events.duration_ticks);
					check_field("control_value", TICK_W'(want.control_value),
						TICK_W'(events.control_value));
					check_field("delta_ticks", want.delta_ticks, events.delta_ticks);
				end
			end
			if (track.valid && track.ready)
				decode_beat(track.opcode, track.data_byte, track.table_index, track.table_value);
			outstanding <= predicted_events.size();
			failures    <= fail_cnt;
		end
	end

endmodule

/* tb/sv/tb_music_track_command_decoder.sv */
// stimulus, handshake pacing and verdict for the music track command decoder
module tb_music_track_command_decoder;
	import mtcd_pkg::*;
	import mtcd_cmd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_BEATS = 800;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;
	int   beats_sent = 0;
	int   ignored_beats = 0;
	int   gap_pct = 0;
	logic calm = 1'b0;
	logic [TABLE_VAL_W-1:0] length_shadow [TABLE_ENTRIES];

	mtcd_in_if  track ();
	mtcd_out_if events ();

	music_track_command_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.track  (track),
		.events (events)
	);

	mtcd_event_checker event_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.track       (track),
		.events      (events),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_rate(int step);
		case ($urandom_range(2))
			0: return 0;
			1: return step;
			default: return 4 * step;
		endcase
	endfunction

	function automatic logic [7:0] command_code(logic ctrl, logic [1:0] mode, logic [4:0] sel);
		return {ctrl, mode, sel};
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [7:0] b,
			input logic [TABLE_IDX_W-1:0] idx, input logic [TABLE_VAL_W-1:0] val);
		if (beats_sent % 50 == 0)
			gap_pct = idle_rate(8);
		if (!calm && $urandom_range(99) < gap_pct) begin
			track.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		track.valid       <= 1'b1;
		track.opcode      <= op;
		track.data_byte   <= b;
		track.table_index <= idx;
		track.table_value <= val;
		do @(posedge clk); while (!track.ready);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(OP_STREAM, b, TABLE_IDX_W'($urandom), TABLE_VAL_W'($urandom));
	endtask

	task automatic restart();
		send_beat(OP_TRACK_START, 8'($urandom), TABLE_IDX_W'($urandom), TABLE_VAL_W'($urandom));
	endtask

	task automatic write_length(input logic [TABLE_IDX_W-1:0] idx,
			input logic [TABLE_VAL_W-1:0] val);
		length_shadow[idx] = val;
		send_beat(OP_TABLE_WR, 8'($urandom), idx, val);
	endtask

	task automatic send_varlen();
		int         n;
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(19);
		n = pick < 14 ? 1 : pick < 17 ? 2 : pick < 18 ? 3 : VARLEN_MAX_BYTES;
		for (int k = 1; k <= n; k++) begin
			b = 8'($urandom);
			if (k < n)
				b[7] = 1'b1;
			else if (n < VARLEN_MAX_BYTES)
				b[7] = 1'b0;
			send_byte(b);
		end
	endtask

	task automatic send_delta(input logic [1:0] mode);
		if (mode == MODE_VAR_DELTA)
			send_varlen();
		else if (mode == MODE_IDX_DELTA)
			send_byte(8'($urandom));
	endtask

	task automatic send_note(input logic [1:0] mode, input logic [4:0] sel,
			input logic [7:0] note_b);
		send_byte(command_code(1'b0, mode, sel));
		send_byte(note_b);
		send_delta(mode);
		if (length_shadow[sel] == 0)
			send_varlen();
		if (note_b[7])
			send_byte(8'($urandom));
	endtask

	task automatic send_control(input logic [1:0] mode, input logic [4:0] sel);
		send_byte(command_code(1'b1, mode, sel));
		if (sel == SEL_TWO_PARAM) begin
			send_byte(8'($urandom));
			send_byte(8'($urandom));
		end else if (sel != SEL_NO_PARAM) begin
			send_byte(8'($urandom));
		end
		send_delta(mode);
	endtask

	// end of track, a few bytes that must be dropped, then a fresh track
	task automatic close_track(input logic [1:0] mode);
		send_byte(command_code(1'b1, mode, SEL_END));
		repeat ($urandom_range(1, 3)) begin
			send_byte(8'($urandom));
			ignored_beats++;
		end
		restart();
	endtask

	// stall bursts on the event side
	initial begin
		int stall_pct;
		int cycle;
		stall_pct = 0;
		cycle = 0;
		events.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 60 == 0)
				stall_pct = idle_rate(5);
			if (!calm && $urandom_range(99) < stall_pct) begin
				events.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			events.ready <= 1'b1;
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((track.valid && track.ready) || (events.valid && events.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL music_track_command_decoder");
		$finish;
	end

	initial begin
		logic [7:0]             opening [$];
		logic [TABLE_VAL_W-1:0] v;
		int                     pick;
		int                     m;
		arst_n            <= 1'b0;
		track.valid       <= 1'b0;
		track.opcode      <= OP_STREAM;
		track.data_byte   <= 8'd0;
		track.table_index <= '0;
		track.table_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// every entry written before any read, every fourth left at zero
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (i % 4 == 0)
				v = '0;
			else if (i == TABLE_ENTRIES - 1)
				v = '1;
			else if (i == 1)
				v = 16'd1;
			else
				v = TABLE_VAL_W'($urandom_range(1, 65535));
			write_length(TABLE_IDX_W'(i), v);
		end

		opening = {
			command_code(1'b0, MODE_FIXED, 5'h00), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			command_code(1'b0, MODE_VAR_DELTA, 5'h1F), 8'h00, 8'h7F,
			command_code(1'b0, MODE_IDX_DELTA, 5'h1F), 8'h80, 8'hFF, 8'hFF,
			command_code(1'b0, MODE_LEN_DELTA, 5'h01), 8'h05,
			command_code(1'b1, MODE_LEN_DELTA, 5'h0F), command_code(1'b1, MODE_LEN_DELTA, 5'h1F),
			command_code(1'b1, MODE_LEN_DELTA, 5'h10), command_code(1'b1, MODE_LEN_DELTA, 5'h00),
			command_code(1'b1, MODE_FIXED, SEL_TEMPO), 8'hFF,
			command_code(1'b1, MODE_FIXED, SEL_REVERB), 8'h01,
			command_code(1'b1, MODE_FIXED, SEL_PROGRAM), 8'h02,
			command_code(1'b1, MODE_FIXED, SEL_VOLUME), 8'h7F,
			command_code(1'b1, MODE_FIXED, SEL_PAN), 8'h40,
			command_code(1'b1, MODE_FIXED, SEL_EXPRESSION), 8'h80,
			command_code(1'b1, MODE_VAR_DELTA, SEL_TWO_PARAM), 8'h12, 8'h34, 8'h81, 8'h00,
			command_code(1'b1, MODE_IDX_DELTA, SEL_NO_PARAM), 8'h1F,
			command_code(1'b1, MODE_FIXED, SEL_LOOP), 8'h00,
			command_code(1'b1, MODE_VAR_DELTA, 5'h1E), 8'h55, 8'hFF, 8'hFF, 8'hFF, 8'h7F
		};
		foreach (opening[i])
			send_byte(opening[i]);

		// length entry rewritten while its command is still open
		send_byte(command_code(1'b0, MODE_VAR_DELTA, 5'h02));
		send_byte(8'h3C);
		write_length(5'd2, 16'h0ABC);
		send_byte(8'h05);

		// new track dropping an open command
		send_byte(command_code(1'b0, MODE_VAR_DELTA, 5'h03));
		send_byte(8'h90);
		send_byte(8'h81);
		restart();

		send_beat(OP_NONE, 8'($urandom), TABLE_IDX_W'($urandom), TABLE_VAL_W'($urandom));
		ignored_beats++;
		close_track(MODE_FIXED);

		while (beats_sent - ignored_beats < RANDOM_BEATS) begin
			calm = (beats_sent - ignored_beats > RANDOM_BEATS - 100);
			pick = $urandom_range(99);
			m = $urandom_range(2);
			if (m != 0)
				m++;
			if (pick < 45) begin
				send_note(2'($urandom_range(3)), 5'($urandom_range(31)), 8'($urandom));
			end else if (pick < 60) begin
				send_byte(command_code(1'b1, MODE_LEN_DELTA, 5'($urandom_range(31))));
			end else if (pick < 80) begin
				send_control(2'(m), 5'($urandom_range(1, 31)));
			end else if (pick < 83) begin
				close_track(2'(m));
			end else if (pick < 88) begin
				v = TABLE_VAL_W'($urandom);
				case ($urandom_range(7)) inside
					0, 1: v = '0;
					2: v = '1;
					default: ;
				endcase
				write_length(TABLE_IDX_W'($urandom), v);
			end else if (pick < 91) begin
				send_byte(command_code(1'b0, 2'($urandom_range(3)), 5'($urandom_range(31))));
				if ($urandom_range(1))
					send_byte(8'($urandom));
				restart();
			end else if (pick < 93) begin
				send_beat(OP_NONE, 8'($urandom), TABLE_IDX_W'($urandom), TABLE_VAL_W'($urandom));
				ignored_beats++;
			end else begin
				send_byte(8'($urandom));
			end
		end
		track.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("PASS music_track_command_decoder");
		else
			$display("FAIL music_track_command_decoder");
		$finish;
	end

endmodule
